[src/ppe_pkg.sv]
// Shared types, constants and helper functions of the palette expander.
`default_nettype none

package ppe_pkg;

	// Default sizes
	localparam int MAX_WIDTH_DEF     = 1024;
	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int PIXEL_WIDTH_DEF   = 32;

	// Queue depths
	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = $clog2(FQ_DEPTH);
	localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	// Configuration port
	localparam int CFG_IW = 1;
	localparam int CFG_DW = 11;
	localparam logic [CFG_IW-1:0] REG_PIXEL_BITS = 1'd0;
	localparam logic [CFG_IW-1:0] REG_ROW_WIDTH  = 1'd1;

	// Request function codes
	typedef enum logic [1:0] {
		FUNC_PAL   = 2'd0,
		FUNC_START = 2'd1,
		FUNC_DATA  = 2'd2
	} func_t;

	// Input request
	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  data_byte;
		logic [7:0]  palette_index;
		logic [31:0] palette_pixel;
	} item_t;

	// Classified request held between front and back
	typedef struct packed {
		func_t       kind;
		logic [7:0]  data_byte;
		logic [7:0]  palette_index;
		logic [31:0] palette_pixel;
	} cmd_t;

	// Result request
	typedef struct packed {
		logic [31:0] pixel_value;
		logic [7:0]  color_index;
		logic [9:0]  column;
		logic        row_end;
		logic        last;
	} res_t;

	// Bits per pixel actually used: zero or above eight means eight
	function automatic logic [3:0] eff_bits(input logic [3:0] b);
		logic [3:0] r;
		if (b == 4'd0 || b > 4'd8) r = 4'd8;
		else r = b;
		return r;
	endfunction

	// Whole pixels per byte for a given effective width
	function automatic logic [3:0] pix_count(input logic [3:0] b);
		logic [3:0] r;
		case (b)
			4'd1: r = 4'd8;
			4'd2: r = 4'd4;
			4'd3: r = 4'd2;
			4'd4: r = 4'd2;
			default: r = 4'd1;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[src/ppe_front.sv]
// Front end: accepts requests, drops the meaningless ones, queues the rest.
`default_nettype none

module ppe_front import ppe_pkg::*; #(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	output logic       full,
	input  wire item_t item,
	output logic       fq_valid,
	output cmd_t       fq_item,
	input  wire logic  fq_pop
);

	logic [FQ_CW-1:0] cnt_q;
	logic [FQ_AW-1:0] wr_q, rd_q;
	cmd_t             buf_q [FQ_DEPTH];
	logic             accept, keep, idx_ok;
	cmd_t             cmd;

	assign full   = (cnt_q == FQ_CW'(FQ_DEPTH));
	assign accept = push && !full;
	assign idx_ok = ({1'b0, item.palette_index} < 9'(PALETTE_DEPTH));

	// Classify: unused code and out-of-range palette writes have no effect
	always_comb begin
		cmd.kind          = FUNC_DATA;
		cmd.data_byte     = item.data_byte;
		cmd.palette_index = item.palette_index;
		cmd.palette_pixel = item.palette_pixel;
		keep              = 1'b0;
		case (item.func)
			FUNC_PAL: begin
				cmd.kind = FUNC_PAL;
				keep     = idx_ok;
			end
			FUNC_START: begin
				cmd.kind = FUNC_START;
				keep     = 1'b1;
			end
			FUNC_DATA: begin
				cmd.kind = FUNC_DATA;
				keep     = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	// Queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= '0;
			rd_q  <= '0;
		end else begin
			if (accept && keep) wr_q <= wr_q + FQ_AW'(1);
			if (fq_pop) rd_q <= rd_q + FQ_AW'(1);
			cnt_q <= cnt_q + FQ_CW'(accept && keep) - FQ_CW'(fq_pop);
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (accept && keep) buf_q[wr_q] <= cmd;
	end

	assign fq_valid = (cnt_q != '0);
	assign fq_item  = buf_q[rd_q];

endmodule

`default_nettype wire

[src/ppe_back.sv]
// Back end: palette store, column counter and pixel-by-pixel byte expansion.
`default_nettype none

module ppe_back import ppe_pkg::*; #(
	parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
	parameter int PIXEL_WIDTH   = PIXEL_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [3:0]        pixel_bits,
	input  wire logic [CFG_DW-1:0] row_width,
	input  wire logic              fq_valid,
	input  wire cmd_t              fq_item,
	output logic                   fq_pop,
	input  wire logic [OQ_CW-1:0]  oq_count,
	output logic                   oq_push,
	output res_t                   oq_item
);

	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = (CW + 1 > CFG_DW) ? CW + 1 : CFG_DW;

	// Palette store and valid marks
	logic [PIXEL_WIDTH-1:0]   pal_mem [PALETTE_DEPTH];
	logic [PALETTE_DEPTH-1:0] pal_vld_q;

	// Expansion state
	logic          act_q;
	logic [7:0]    sh_q;
	logic [2:0]    k_q;
	logic [CW-1:0] col_q;

	// Lookup stage
	logic                   vld_s1;
	logic [7:0]             ci_s1;
	logic [CW-1:0]          col_s1;
	logic                   rend_s1, lst_s1, inr_s1, hit_s1;
	logic [PIXEL_WIDTH-1:0] rd_s1;

	logic [3:0]       bits, cnt;
	logic [3:0]       sa;
	logic [7:0]       ci;
	logic [WW-1:0]    rw, effw;
	logic             rend, lst, inr;
	logic             credit_ok, issue, fin, free, take;
	logic [OQ_CW-1:0] occ;

	// Effective pixel size and row width
	always_comb begin
		bits = eff_bits(pixel_bits);
		cnt  = pix_count(bits);
		sa   = 4'd8 - bits;
		rw   = WW'(row_width);
		if (rw == '0) effw = WW'(1);
		else if (rw > WW'(MAX_WIDTH)) effw = WW'(MAX_WIDTH);
		else effw = rw;
	end

	// Current pixel of the working byte
	always_comb begin
		ci   = sh_q >> sa;
		rend = ((WW'(col_q) + WW'(1)) >= effw);
		lst  = rend || (({1'b0, k_q} + 4'd1) == cnt);
		inr  = ({1'b0, ci} < 9'(PALETTE_DEPTH));
	end

	// Issue only with a free output slot reserved
	always_comb begin
		occ       = oq_count + OQ_CW'(vld_s1);
		credit_ok = (occ < OQ_CW'(OQ_DEPTH));
		issue     = act_q && credit_ok;
		fin       = issue && lst;
		free      = !act_q || fin;
		take      = free && fq_valid;
		fq_pop    = take;
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q     <= 1'b0;
			k_q       <= '0;
			col_q     <= '0;
			pal_vld_q <= '0;
			vld_s1    <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (issue) begin
				k_q   <= k_q + 3'd1;
				col_q <= rend ? '0 : col_q + CW'(1);
			end
			if (fin) act_q <= 1'b0;
			if (take) begin
				case (fq_item.kind)
					FUNC_DATA: begin
						act_q <= 1'b1;
						k_q   <= '0;
					end
					FUNC_START: begin
						pal_vld_q <= '0;
						col_q     <= '0;
					end
					FUNC_PAL: pal_vld_q[fq_item.palette_index[AW-1:0]] <= 1'b1;
					default: ;
				endcase
			end
		end
	end

	// Working byte shifts up one pixel per issue
	always_ff @(posedge clk) begin
		if (issue) sh_q <= sh_q << bits;
		if (take && fq_item.kind == FUNC_DATA) sh_q <= fq_item.data_byte;
	end

	// Palette memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (take && fq_item.kind == FUNC_PAL)
			pal_mem[fq_item.palette_index[AW-1:0]] <= fq_item.palette_pixel[PIXEL_WIDTH-1:0];
		if (issue) begin
			rd_s1   <= pal_mem[ci[AW-1:0]];
			hit_s1  <= pal_vld_q[ci[AW-1:0]];
			ci_s1   <= ci;
			col_s1  <= col_q;
			rend_s1 <= rend;
			lst_s1  <= lst;
			inr_s1  <= inr;
		end
	end

	// Result formatting
	always_comb begin
		oq_push             = vld_s1;
		oq_item.pixel_value = (inr_s1 && hit_s1) ? 32'(rd_s1) : 32'd0;
		oq_item.color_index = ci_s1;
		oq_item.column      = 10'(col_s1);
		oq_item.row_end     = rend_s1;
		oq_item.last        = lst_s1;
	end

endmodule

`default_nettype wire

[src/ppe_outq.sv]
// Result queue between the expander and the consumer.
`default_nettype none

module ppe_outq import ppe_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             oq_push,
	input  wire res_t             oq_item,
	output logic [OQ_CW-1:0]      oq_count,
	output logic                  empty,
	input  wire logic             pop,
	output res_t                  result
);

	logic [OQ_CW-1:0] cnt_q;
	logic [OQ_AW-1:0] wr_q, rd_q;
	res_t             buf_q [OQ_DEPTH];
	logic             deq;

	assign empty    = (cnt_q == '0);
	assign deq      = pop && !empty;
	assign oq_count = cnt_q;
	assign result   = buf_q[rd_q];

	// Pointers and fill; the producer never pushes into a full queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= '0;
			rd_q  <= '0;
		end else begin
			if (oq_push) wr_q <= wr_q + OQ_AW'(1);
			if (deq) rd_q <= rd_q + OQ_AW'(1);
			cnt_q <= cnt_q + OQ_CW'(oq_push) - OQ_CW'(deq);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (oq_push) buf_q[wr_q] <= oq_item;
	end

endmodule

`default_nettype wire

[src/packed_pixel_palette_expander.sv]
// Data path: input queue, expansion state, lookup stage, result queue. A byte
// yields 1 to 8 pixels through the single lookup port of the palette memory;
// one pixel per cycle while the result queue has room. Palette writes and
// start-image requests wait for an idle back end or a byte's last pixel.
// Reset clears queues, column counter and palette valid marks; pixel_bits
// returns to 8 and row_width to 1. Palette contents are not cleared.
`default_nettype none

module packed_pixel_palette_expander import ppe_pkg::*; #(
	parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
	parameter int PIXEL_WIDTH   = PIXEL_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire item_t             item,
	output logic                   empty,
	input  wire logic              pop,
	output res_t                   result,
	input  wire logic              cfg_we,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data
);

	logic [3:0]        pixel_bits_q;
	logic [CFG_DW-1:0] row_width_q;
	logic              fq_valid, fq_pop, oq_push;
	cmd_t              fq_item;
	res_t              oq_item;
	logic [OQ_CW-1:0]  oq_count;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bits_q <= 4'd8;
			row_width_q  <= CFG_DW'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PIXEL_BITS: pixel_bits_q <= cfg_data[3:0];
				REG_ROW_WIDTH:  row_width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	ppe_front #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.fq_valid (fq_valid),
		.fq_item  (fq_item),
		.fq_pop   (fq_pop)
	);

	ppe_back #(
		.MAX_WIDTH     (MAX_WIDTH),
		.PALETTE_DEPTH (PALETTE_DEPTH),
		.PIXEL_WIDTH   (PIXEL_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_bits (pixel_bits_q),
		.row_width  (row_width_q),
		.fq_valid   (fq_valid),
		.fq_item    (fq_item),
		.fq_pop     (fq_pop),
		.oq_count   (oq_count),
		.oq_push    (oq_push),
		.oq_item    (oq_item)
	);

	ppe_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.oq_push  (oq_push),
		.oq_item  (oq_item),
		.oq_count (oq_count),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

`default_nettype wire

[src/ppe_checker.sv]
// Port-level checks of the palette expander, bound to the top level.
`default_nettype none

module ppe_checker import ppe_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic full,
	input wire logic empty,
	input wire logic pop,
	input wire res_t result
);

	// A pixel that ends its row always ends its byte
	a_row_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.row_end |-> result.last)
		else $error("row end without last");

	// Pixels of one byte come in consecutive columns
	a_column_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !result.last) ##1 !empty |->
		result.column == $past(result.column) + 10'd1)
		else $error("column not consecutive within a byte");

	// A waiting result holds until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed");

	// The input side only fills on an accepted request
	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a request");

endmodule

bind packed_pixel_palette_expander ppe_checker u_chk (.*);

`default_nettype wire
